// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL files that carry concurrent checks (only the top level includes them).
// The including module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define WLLS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds outside of reset.
`define WLLS_NEVER(lbl, cond, msg) \
	`WLLS_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/core/wlls_pkg.sv
// Types and constants for the weighted least-load worker selector.
// Used by the table, datapath, controller and top level; depends on nothing.
package wlls_pkg;

	localparam int OP_W     = 2;
	localparam int SEL_W    = 4;
	localparam int ACTIVE_W = 16;
	localparam int LOAD_W   = 7;
	localparam int RATING_W = 8;
	localparam int CAP_W    = 16;

	// Only this many workers can ever be addressed by a write or outcome request.
	localparam int MAX_ADDR = 2 ** SEL_W;

	// Weighted load is 10 * active + load, then scaled by a rating for comparison.
	localparam int WL_W  = 20;
	localparam int KEY_W = WL_W + RATING_W;

	localparam logic [3:0]          LOAD_SCALE   = 4'd10;
	localparam logic [RATING_W-1:0] RATING_FLOOR = 8'd1;

	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_SELECT  = 2'd1;
	localparam logic [OP_W-1:0] OP_OUTCOME = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [SEL_W-1:0]    worker_sel;
		logic [ACTIVE_W-1:0] active_count;
		logic [LOAD_W-1:0]   load_pct;
		logic [RATING_W-1:0] rating_val;
		logic                running;
		logic [CAP_W-1:0]    capacity;
		logic                send_ok;
	} req_t;

	typedef struct packed {
		logic                found;
		logic [SEL_W-1:0]    chosen_index;
		logic [ACTIVE_W-1:0] task_count;
	} res_t;

	typedef struct packed {
		logic [ACTIVE_W-1:0] active;
		logic [LOAD_W-1:0]   load;
		logic [RATING_W-1:0] rating;
		logic                running;
		logic [CAP_W-1:0]    capacity;
	} worker_rec_t;

	typedef struct packed {
		logic take;
		logic scan;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic is_select;
		logic scan_last;
	} dp_status_t;

endpackage

// File: rtl/core/wlls_table.sv
// Worker record table: one write port and one combinational read port.
// Depends on wlls_pkg for the record type.
module wlls_table import wlls_pkg::*; #(
	parameter int DEPTH = 16,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  worker_rec_t      wdata,
	input  logic [IDX_W-1:0] raddr,
	output worker_rec_t      rdata
);

	worker_rec_t entries_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				entries_q[i] <= '0;
			end
		end else if (we) begin
			entries_q[waddr] <= wdata;
		end
	end

	assign rdata = entries_q[raddr];

endmodule

// File: rtl/core/wlls_datapath.sv
// Datapath: worker table, record update, two-stage scan compare and result register.
// Depends on wlls_pkg and wlls_table; driven by commands from wlls_ctrl.
module wlls_datapath import wlls_pkg::*; #(
	parameter int NUM_WORKERS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output res_t       res
);

	// Workers past the addressable range get no table entry and are never scanned.
	localparam int TBL_DEPTH = (NUM_WORKERS < MAX_ADDR) ? NUM_WORKERS : MAX_ADDR;
	localparam int IDX_W     = $clog2(TBL_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TBL_DEPTH - 1);

	logic             sel_ok;
	logic [IDX_W-1:0] sel_idx;
	logic [IDX_W-1:0] raddr;
	worker_rec_t      rd;
	worker_rec_t      new_rec;
	worker_rec_t      upd_rec;
	worker_rec_t      wdata;
	logic             we;
	logic             elig;
	logic [WL_W-1:0]  wl;
	logic [KEY_W-1:0] lhs;
	logic [KEY_W-1:0] rhs;
	logic             take_best;

	logic [OP_W-1:0]     op_q;
	logic [ACTIVE_W-1:0] cnt_q;
	logic [IDX_W-1:0]    ptr_q;

	logic                vld_s1;
	logic                elig_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [WL_W-1:0]     wl_s1;
	logic [RATING_W-1:0] rating_s1;
	logic [ACTIVE_W-1:0] active_s1;

	logic                have_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [WL_W-1:0]     best_wl_q;
	logic [RATING_W-1:0] best_rating_q;
	logic [ACTIVE_W-1:0] best_active_q;

	res_t res_q;

	assign sel_ok  = 32'(req.worker_sel) < TBL_DEPTH;
	assign sel_idx = req.worker_sel[IDX_W-1:0];
	assign raddr   = cmd.take ? sel_idx : ptr_q;

	wlls_table #(
		.DEPTH(TBL_DEPTH)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (we),
		.waddr (sel_idx),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd)
	);

	always_comb begin
		new_rec.active   = req.active_count;
		new_rec.load     = req.load_pct;
		new_rec.rating   = req.rating_val;
		new_rec.running  = req.running;
		new_rec.capacity = req.capacity;

		upd_rec = rd;
		if (req.send_ok) begin
			if (rd.active != '1) begin
				upd_rec.active = rd.active + ACTIVE_W'(1);
			end
		end else begin
			upd_rec.rating = (rd.rating > RATING_FLOOR) ? rd.rating - RATING_W'(1)
			                                            : RATING_FLOOR;
		end
	end

	assign wdata = (req.op == OP_WRITE) ? new_rec : upd_rec;
	assign we    = cmd.take && sel_ok && (req.op == OP_WRITE || req.op == OP_OUTCOME);

	assign elig = rd.running && (rd.active <= rd.capacity) && (rd.rating > RATING_FLOOR);
	assign wl   = WL_W'(rd.active) * WL_W'(LOAD_SCALE) + WL_W'(rd.load);

	// Exact key compare: the candidate wins only on a strictly smaller scaled load.
	assign lhs       = KEY_W'(wl_s1) * KEY_W'(best_rating_q);
	assign rhs       = KEY_W'(best_wl_q) * KEY_W'(rating_s1);
	assign take_best = vld_s1 && elig_s1 && (!have_q || lhs < rhs);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q <= req.op;
			if (sel_ok && req.op == OP_WRITE) begin
				cnt_q <= req.active_count;
			end else if (sel_ok && req.op == OP_OUTCOME) begin
				cnt_q <= upd_rec.active;
			end else begin
				cnt_q <= '0;
			end
		end
		if (cmd.scan) begin
			elig_s1   <= elig;
			idx_s1    <= ptr_q;
			wl_s1     <= wl;
			rating_s1 <= rd.rating;
			active_s1 <= rd.active;
		end
		if (take_best) begin
			best_idx_q    <= idx_s1;
			best_wl_q     <= wl_s1;
			best_rating_q <= rating_s1;
			best_active_q <= active_s1;
		end
		if (cmd.emit) begin
			if (op_q == OP_SELECT) begin
				res_q.found        <= have_q;
				res_q.chosen_index <= have_q ? SEL_W'(best_idx_q) : '0;
				res_q.task_count   <= have_q ? best_active_q : '0;
			end else begin
				res_q.found        <= 1'b0;
				res_q.chosen_index <= '0;
				res_q.task_count   <= cnt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			vld_s1 <= 1'b0;
			have_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan;
			if (cmd.take) begin
				ptr_q  <= '0;
				have_q <= 1'b0;
			end else begin
				if (cmd.scan) begin
					ptr_q <= ptr_q + IDX_W'(1);
				end
				if (take_best) begin
					have_q <= 1'b1;
				end
			end
		end
	end

	assign status.is_select = (req.op == OP_SELECT);
	assign status.scan_last = (ptr_q == LAST_IDX);
	assign res              = res_q;

endmodule

// File: rtl/core/wlls_ctrl.sv
// Controller state machine: request acceptance, table scan sequencing, result hand-off.
// Depends on wlls_pkg for the command and status types.
module wlls_ctrl import wlls_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       res_valid,
	input  logic       res_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   res_valid_q;
	logic   slot_free;

	assign slot_free = !res_valid_q || res_ready;

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = status.is_select ? ST_SCAN : ST_EMIT;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_d = ST_FLUSH;
				end
			end
			// The last scanned worker is compared against the best during this cycle.
			ST_FLUSH: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;

endmodule

// File: rtl/core/weighted_least_load_selector.sv
// Weighted least-load worker selector, top level (controller plus datapath).
// Write and outcome requests pass from IDLE to EMIT; the result is registered when the slot is free.
// A select request scans one worker per cycle through SCAN, then FLUSH and EMIT; the rate is
// set by the single table read port and the one-compare-per-cycle best tracker.
// A new request is taken while the previous result still waits in the output register.
// Asynchronous active-low reset clears every worker record and the control state.
module weighted_least_load_selector import wlls_pkg::*; #(
	parameter int NUM_WORKERS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	`include "assert_macros.svh"

	dp_cmd_t    cmd;
	dp_status_t status;

	wlls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.status   (status),
		.cmd      (cmd)
	);

	wlls_datapath #(
		.NUM_WORKERS(NUM_WORKERS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.status(status),
		.res   (res)
	);

	`WLLS_NEVER(a_take_emit_excl, cmd.take && (cmd.emit || cmd.scan), "take overlaps scan or emit")
	`WLLS_ASSERT(a_scan_blocks_req, cmd.scan |-> !req_ready, "request accepted during a scan")
	`WLLS_ASSERT(a_emit_shows, cmd.emit |=> res_valid, "emitted result not presented")
	`WLLS_ASSERT(a_found_range, res_valid && res.found |-> 32'(res.chosen_index) < NUM_WORKERS,
		"chosen worker index out of range")

endmodule

// File: sim/weighted_least_load_selector_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the weighted least-load worker selector: keeps its own worker table,
// predicts one result per accepted request and compares results in order.
// Depends on wlls_pkg for the request, result and worker record types.
module weighted_least_load_selector_checker import wlls_pkg::*; #(
	parameter int NUM_WORKERS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic res_valid,
	input  logic res_ready,
	input  res_t res,
	output int   fail_count,
	output int   pending
);

	worker_rec_t workers [NUM_WORKERS];
	res_t        awaited_results [$];

	function automatic logic [63:0] scaled_load(worker_rec_t w);
		return 64'(w.active) * 64'(LOAD_SCALE) + 64'(w.load);
	endfunction

	// Applies one request to the worker table and returns the result it should produce.
	function automatic res_t apply_request(req_t r);
		res_t        out;
		worker_rec_t w;
		logic        have;
		int          best;
		int          i;
		out  = '0;
		have = 1'b0;
		best = 0;
		case (r.op)
			OP_WRITE: begin
				if (r.worker_sel < NUM_WORKERS) begin
					w.active   = r.active_count;
					w.load     = r.load_pct;
					w.rating   = r.rating_val;
					w.running  = r.running;
					w.capacity = r.capacity;
					workers[r.worker_sel] = w;
					out.task_count = w.active;
				end
			end
			OP_SELECT: begin
				for (i = 0; i < NUM_WORKERS; i++) begin
					w = workers[i];
					if (w.running && w.active <= w.capacity && w.rating > RATING_FLOOR) begin
						// Keys are compared by cross-multiplying; a strict less-than keeps ties
						// on the lowest index.
						if (!have || scaled_load(w) * workers[best].rating <
								scaled_load(workers[best]) * w.rating) begin
							best = i;
						end
						have = 1'b1;
					end
				end
				if (have) begin
					out.found        = 1'b1;
					out.chosen_index = best[SEL_W-1:0];
					out.task_count   = workers[best].active;
				end
			end
			OP_OUTCOME: begin
				if (r.worker_sel < NUM_WORKERS) begin
					w = workers[r.worker_sel];
					if (r.send_ok) begin
						if (w.active != '1)
							w.active = w.active + 1'b1;
					end else begin
						w.rating = (w.rating > RATING_FLOOR) ? w.rating - 1'b1 : RATING_FLOOR;
					end
					workers[r.worker_sel] = w;
					out.task_count = w.active;
				end
			end
			default: ;
		endcase
		return out;
	endfunction

	task automatic report_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			foreach (workers[i])
				workers[i] = '0;
			awaited_results.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			// A result never belongs to a request taken at the same edge, so check it first.
			if (res_valid && res_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got found=%0d index=%0d count=%0d",
						$time, res.found, res.chosen_index, res.task_count);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					report_field("found", int'(want.found), int'(res.found));
					report_field("chosen_index", int'(want.chosen_index),
						int'(res.chosen_index));
					report_field("task_count", int'(want.task_count), int'(res.task_count));
				end
			end
			if (req_valid && req_ready)
				awaited_results.insert(awaited_results.size(), apply_request(req));
			pending = awaited_results.size();
		end
	end

endmodule

// File: sim/weighted_least_load_selector_test.sv
`timescale 1ns / 1ps
// Top of the selector testbench: clock, reset, request and result handshakes, watchdog.
// Depends on wlls_pkg, the selector RTL and weighted_least_load_selector_checker.
module weighted_least_load_selector_test;
	import wlls_pkg::*;

	localparam int               WORKERS       = 16;
	localparam logic [OP_W-1:0]  OP_UNUSED     = 2'd3;
	localparam int               RANDOM_ITEMS  = 1580;
	localparam int               IDLE_LIMIT    = 2000;
	localparam int               SETTLE_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic res_valid;
	logic res_ready;
	res_t res;
	int   fail_count;
	int   pending;
	int   idle_cycles;
	logic sender_quiet;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	weighted_least_load_selector #(
		.NUM_WORKERS(WORKERS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	weighted_least_load_selector_checker #(
		.NUM_WORKERS(WORKERS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (res_valid && res_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("weighted_least_load_selector_test: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side: random stalls per result, with occasional runs of back-to-back acceptance.
	initial begin
		int stall;
		int burst_left;
		res_ready  = 1'b0;
		burst_left = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (burst_left > 0) begin
				burst_left--;
				stall = 0;
			end else begin
				stall = $urandom_range(0, 8);
				if ($urandom_range(0, 19) == 0)
					burst_left = $urandom_range(20, 60);
			end
			if (stall != 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			@(negedge clk);
		end
	end

	function automatic req_t make_request(logic [OP_W-1:0] op, int sel, int active, int load,
			int rating, logic running, int capacity, logic ok);
		req_t r;
		r.op           = op;
		r.worker_sel   = sel[SEL_W-1:0];
		r.active_count = active[ACTIVE_W-1:0];
		r.load_pct     = load[LOAD_W-1:0];
		r.rating_val   = rating[RATING_W-1:0];
		r.running      = running;
		r.capacity     = capacity[CAP_W-1:0];
		r.send_ok      = ok;
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(req_t item);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		req_t        item;
		logic [63:0] noise;
		int          pick;
		int          active;
		int          capacity;
		int          n;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		sender_quiet = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Empty table, unused opcode, saturation and rating floor.
		send_request(make_request(OP_SELECT, 0, 0, 0, 0, 1'b0, 0, 1'b0));
		send_request(make_request(OP_UNUSED, 15, 65535, 127, 255, 1'b1, 65535, 1'b1));
		send_request(make_request(OP_WRITE, 0, 65535, 127, 255, 1'b1, 65535, 1'b1));
		send_request(make_request(OP_OUTCOME, 0, 0, 0, 0, 1'b0, 0, 1'b1));
		send_request(make_request(OP_WRITE, 15, 0, 0, 2, 1'b1, 0, 1'b0));
		send_request(make_request(OP_SELECT, 0, 0, 0, 0, 1'b0, 0, 1'b0));
		send_request(make_request(OP_WRITE, 1, 0, 0, 0, 1'b1, 10, 1'b0));
		send_request(make_request(OP_OUTCOME, 1, 0, 0, 0, 1'b0, 0, 1'b0));
		send_request(make_request(OP_WRITE, 2, 0, 0, 1, 1'b1, 10, 1'b0));
		send_request(make_request(OP_OUTCOME, 2, 0, 0, 0, 1'b0, 0, 1'b0));
		// Equal keys across workers 3, 4 and 5; the lowest eligible index must win.
		send_request(make_request(OP_WRITE, 15, 0, 0, 2, 1'b0, 0, 1'b0));
		send_request(make_request(OP_WRITE, 5, 1, 0, 2, 1'b1, 1, 1'b0));
		send_request(make_request(OP_WRITE, 4, 2, 0, 4, 1'b1, 100, 1'b0));
		send_request(make_request(OP_WRITE, 3, 0, 10, 2, 1'b1, 0, 1'b0));
		send_request(make_request(OP_SELECT, 0, 0, 0, 0, 1'b0, 0, 1'b0));
		send_request(make_request(OP_WRITE, 3, 6, 0, 2, 1'b1, 5, 1'b0));
		send_request(make_request(OP_SELECT, 0, 0, 0, 0, 1'b0, 0, 1'b0));
		send_request(make_request(OP_OUTCOME, 4, 0, 0, 0, 1'b0, 0, 1'b1));
		send_request(make_request(OP_SELECT, 0, 0, 0, 0, 1'b0, 0, 1'b0));
		send_request(make_request(OP_OUTCOME, 5, 0, 0, 0, 1'b0, 0, 1'b0));
		send_request(make_request(OP_SELECT, 0, 0, 0, 0, 1'b0, 0, 1'b0));
		send_request(make_request(OP_OUTCOME, 15, 0, 0, 0, 1'b0, 0, 1'b1));
		send_request(make_request(OP_OUTCOME, 0, 0, 0, 0, 1'b0, 0, 1'b0));
		wait_for_results();

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			sender_quiet = (n % 400) < 50;
			if (n % 250 == 249)
				wait_for_results();
			noise = {$urandom(), $urandom()};
			item  = noise[$bits(req_t)-1:0];
			pick  = $urandom_range(0, 99);
			if (pick < 35) begin
				item.op = OP_WRITE;
				pick = $urandom_range(0, 9);
				if (pick == 0)
					active = $urandom_range(0, 65535);
				else if (pick == 1)
					active = $urandom_range(65530, 65535);
				else
					active = $urandom_range(0, 40);
				if ($urandom_range(0, 9) == 0)
					capacity = $urandom_range(0, 65535);
				else
					capacity = active + $urandom_range(0, 20);
				if (capacity > 65535)
					capacity = 65535;
				item.active_count = active[ACTIVE_W-1:0];
				item.capacity     = capacity[CAP_W-1:0];
				item.load_pct     = LOAD_W'(($urandom_range(0, 9) == 0)
					? $urandom_range(101, 127) : $urandom_range(0, 100));
				pick = $urandom_range(0, 9);
				// Narrow ratings now and then make equal keys more likely.
				if (pick == 0)
					item.rating_val = RATING_W'($urandom_range(0, 1));
				else if (pick < 4)
					item.rating_val = RATING_W'($urandom_range(2, 8));
				else
					item.rating_val = RATING_W'($urandom_range(2, 255));
				item.running = ($urandom_range(0, 4) != 0);
			end else if (pick < 65) begin
				item.op = OP_SELECT;
			end else if (pick < 95) begin
				item.op = OP_OUTCOME;
			end else begin
				item.op = OP_UNUSED;
			end
			send_request(item);
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("weighted_least_load_selector_test: clean");
		else
			$display("weighted_least_load_selector_test: errors");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/wlls_pkg.sv
rtl/core/wlls_table.sv
rtl/core/wlls_datapath.sv
rtl/core/wlls_ctrl.sv
rtl/core/weighted_least_load_selector.sv
sim/weighted_least_load_selector_checker.sv
sim/weighted_least_load_selector_test.sv
